// ===== src/gkf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the Gauss-Kruger forward core.
// Used by every module under src; depends on nothing.
package gkf_pkg;

	localparam int WF = 30;

	typedef logic signed [63:0] word_t;

	localparam word_t LIM = 64'sh4000_0000_0000_0000;
	localparam word_t ONE_Q30 = 64'sh0000_0000_4000_0000;
	localparam word_t MERID_COEF = 64'sd63675584968;
	localparam longint unsigned DEG_DIV = 64'd5729577951;

	localparam word_t NORTH_LO = -64'sd11000000000;
	localparam word_t NORTH_HI = 64'sd11000000000;
	localparam word_t EAST_LO = -64'sd20000000000;
	localparam word_t EAST_HI = 64'sd90000000000;

	localparam int NORTH_W = 35;
	localparam int EAST_W = 38;

	// x series cubics P0..P4, then y series cubics Q0..Q3; coefficients in 1e-4 m
	localparam word_t XP [5][4] = '{
		'{64'sd160028900, 64'sd669607, 64'sd3515, 64'sd0},
		'{64'sd15945612500, 64'sd53365350, 64'sd267900, 64'sd1490},
		'{64'sd6724834000, -64'sd8112199000, 64'sd54200000, -64'sd106000},
		'{64'sd2781940000, -64'sd8301740000, 64'sd5724340000, -64'sd160100000},
		'{64'sd1095000000, -64'sd5747000000, 64'sd8637000000, -64'sd3986000000}
	};

	localparam word_t YQ [4][4] = '{
		'{64'sd63782450000, 64'sd213461415, 64'sd1071590, 64'sd5977},
		'{64'sd10702041600, -64'sd21368266600, 64'sd179800, -64'sd119900},
		'{64'sd2708060000, -64'sd15234170000, 64'sd13276450000, -64'sd217010000},
		'{64'sd796900000, -64'sd8661900000, 64'sd17303600000, -64'sd9454600000}
	};

	// Taylor term divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
	localparam int SIN_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
	localparam int COS_DIV [9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

	typedef word_t cm_tab_t [64];

	typedef struct packed {
		word_t lat;
		word_t lon_off;
		word_t prefix;
	} pt_t;

	// central meridian of zone n in Q30, evaluated at elaboration
	function automatic cm_tab_t cm_table();
		cm_tab_t tab;
		longint d;
		longint unsigned m, a, q1, r, q;
		for (int n = 0; n < 64; n++) begin
			d = 6 * longint'(n) - 3;
			m = (d < 0) ? longint'(-d) : d;
			a = m * 64'd390625 * 64'd16384;
			q1 = a / DEG_DIV;
			r = a % DEG_DIV;
			q = (q1 << 24) + ((r << 24) / DEG_DIV);
			tab[n] = (d < 0) ? -word_t'(q) : word_t'(q);
		end
		return tab;
	endfunction

	localparam cm_tab_t CM_TAB = cm_table();

	function automatic word_t poly_coef(input int i, input int j);
		if (i < 5) begin
			return XP[i][j];
		end else begin
			return YQ[i-5][j];
		end
	endfunction

	function automatic word_t clamp_lim(input word_t v);
		if (v > LIM) begin
			return LIM;
		end else if (v < -LIM) begin
			return -LIM;
		end
		return v;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		return clamp_lim(clamp_lim(a) + clamp_lim(b));
	endfunction

endpackage

// ===== src/gauss_kruger_forward_core.sv =====
`timescale 1ns / 1ps
// Gauss-Kruger forward projection (GOST series, six degree zones).
// Input stream s_axis: one point per transfer, latitude and longitude in radians
// (ANGLE_FRAC_BITS fraction bits) and the zone number. Output stream m_axis: one
// plane coordinate pair per point, northing and easting in millimetres, saturated.
// Throughput: one point per cycle when the receiver keeps m_axis_tready high.
// Results pass the front register, the queue and the datapath; the nine
// sine/cosine Taylor terms (multiply, divide by a constant, add) set most of
// the datapath's depth, then products, cubics, Horner nesting and rounding.
// A front register and a four-entry queue sit ahead of the datapath.
// When m_axis_tready is low with a result valid, the whole datapath holds;
// the queue keeps taking points until full, then s_axis_tready drops.
// Reset (arst_n low, asynchronous) empties the queue and the pipeline; no points
// are in flight afterwards. The block has no configuration.
module gauss_kruger_forward_core import gkf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 29
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // latitude[30:0], longitude[62:31], zone[68:63]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // northing_mm[34:0], easting_mm[72:35]
);

	logic push_valid, push_ready, pop_valid, pop;
	pt_t push_data, pop_data;
	logic [NORTH_W-1:0] northing_mm;
	logic [EAST_W-1:0] easting_mm;

	gkf_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	gkf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
	);

	gkf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pop_valid), .in_pop(pop), .in_data(pop_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.northing_mm(northing_mm), .easting_mm(easting_mm)
	);

	assign m_axis_tdata = {7'd0, easting_mm, northing_mm};

endmodule

// ===== src/gkf_mulshr.sv =====
`timescale 1ns / 1ps
// Two-stage floored product a*b/2^SH, clamped to +-2^62.
// Four 32x32 partial products in stage 1, sum, round and shift in stage 2. Uses gkf_pkg.
module gkf_mulshr import gkf_pkg::*; #(
	parameter int SH = 30
) (
	input  logic  clk,
	input  logic  en,
	input  word_t a,
	input  word_t b,
	output word_t y
);

	localparam logic [127:0] RND = (128'd1 << SH) - 128'd1;

	logic [63:0] ua, ub;
	logic [63:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic neg_s1;
	logic [127:0] full, qv;
	word_t mag;

	assign ua = a[63] ? (~a + 64'd1) : a;
	assign ub = b[63] ? (~b + 64'd1) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			p0_s1 <= ua[31:0] * ub[31:0];
			p1_s1 <= ua[31:0] * ub[63:32];
			p2_s1 <= ua[63:32] * ub[31:0];
			p3_s1 <= ua[63:32] * ub[63:32];
		end
	end

	// negative products: add 2^SH-1 to the magnitude so the shift floors
	always_comb begin
		full = {64'd0, p0_s1} + {32'd0, p1_s1, 32'd0} + {32'd0, p2_s1, 32'd0}
			+ {p3_s1, 64'd0} + (neg_s1 ? RND : 128'd0);
		qv = full >> SH;
		mag = (qv > {64'd0, LIM}) ? LIM : word_t'(qv[63:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= neg_s1 ? -mag : mag;
		end
	end

endmodule

// ===== src/gkf_divc.sv =====
`timescale 1ns / 1ps
// Pipelined divide of a signed word by a small constant, one byte of quotient per stage.
// Truncates toward zero, or floors when FLOOR is set. Uses gkf_pkg.
module gkf_divc import gkf_pkg::*; #(
	parameter int D = 10,
	parameter bit FLOOR = 1'b0
) (
	input  logic  clk,
	input  logic  en,
	input  word_t v,
	output word_t q
);

	localparam int S = 27;
	localparam int RW = $clog2(D);
	localparam logic [63:0] M = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);

	logic [63:0] mag;
	logic [63:0] w_s [9];
	logic neg_s [9];
	logic [RW-1:0] r_s [7];

	always_comb begin
		mag = v[63] ? (~v + 64'd1) : v;
		if (FLOOR && v[63]) begin
			mag = mag + 64'(D - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s[0] <= mag;
			neg_s[0] <= v[63];
		end
	end

	// remainder < D, so {rem, byte} / D is one byte; reciprocal is exact below 2^17
	for (genvar j = 0; j < 8; j++) begin : g_dig
		logic [RW-1:0] rin;
		logic [RW+7:0] num;
		logic [63:0] prod;
		logic [7:0] qd;
		logic [RW+7:0] rem;

		if (j == 0) begin : g_first
			assign rin = '0;
		end else begin : g_next
			assign rin = r_s[j-1];
		end

		assign num = {rin, w_s[j][63:56]};
		assign prod = 64'(num) * M;
		assign qd = prod[S+7:S];
		assign rem = num - (RW+8)'(qd * D);

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[j+1] <= {w_s[j][55:0], qd};
				neg_s[j+1] <= neg_s[j];
			end
		end

		if (j < 7) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[j] <= rem[RW-1:0];
				end
			end
		end
	end

	assign q = neg_s[8] ? -word_t'(w_s[8]) : word_t'(w_s[8]);

endmodule

// ===== src/gkf_dly.sv =====
`timescale 1ns / 1ps
// Word delay line of N enabled stages.
// Uses gkf_pkg.
module gkf_dly import gkf_pkg::*; #(
	parameter int N = 1
) (
	input  logic  clk,
	input  logic  en,
	input  word_t d,
	output word_t q
);

	word_t tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];

endmodule

// ===== src/gkf_hstep.sv =====
`timescale 1ns / 1ps
// One Horner step y = c +/- a*b/2^30 with saturating add, registered after the product.
// b is passed on aligned with y for the next step. Uses gkf_pkg, gkf_mulshr, gkf_dly.
module gkf_hstep import gkf_pkg::*; #(
	parameter bit NEG = 1'b0
) (
	input  logic  clk,
	input  logic  en,
	input  word_t a,
	input  word_t b,
	input  word_t c,
	output word_t y,
	output word_t b_o
);

	word_t p, pn, c_d;

	gkf_mulshr #(.SH(WF)) u_mul (.clk(clk), .en(en), .a(a), .b(b), .y(p));
	gkf_dly #(.N(2)) u_c (.clk(clk), .en(en), .d(c), .q(c_d));
	gkf_dly #(.N(3)) u_b (.clk(clk), .en(en), .d(b), .q(b_o));

	assign pn = NEG ? -p : p;

	always_ff @(posedge clk) begin
		if (en) begin
			y <= sat_add(c_d, pn);
		end
	end

endmodule

// ===== src/gkf_tstep.sv =====
`timescale 1ns / 1ps
// One Taylor term of sine and cosine side by side, sharing x^2.
// Uses gkf_pkg, gkf_mulshr, gkf_divc, gkf_dly.
module gkf_tstep import gkf_pkg::*; #(
	parameter int SD = 6,
	parameter int CD = 2
) (
	input  logic  clk,
	input  logic  en,
	input  word_t x2,
	input  word_t st,
	input  word_t ss,
	input  word_t ct,
	input  word_t cs,
	output word_t x2_o,
	output word_t st_o,
	output word_t ss_o,
	output word_t ct_o,
	output word_t cs_o
);

	word_t ps, pc, qs, qc, ss_d, cs_d;

	gkf_mulshr #(.SH(WF)) u_ms (.clk(clk), .en(en), .a(st), .b(x2), .y(ps));
	gkf_mulshr #(.SH(WF)) u_mc (.clk(clk), .en(en), .a(ct), .b(x2), .y(pc));
	gkf_divc #(.D(SD), .FLOOR(1'b0)) u_ds (.clk(clk), .en(en), .v(ps), .q(qs));
	gkf_divc #(.D(CD), .FLOOR(1'b0)) u_dc (.clk(clk), .en(en), .v(pc), .q(qc));
	gkf_dly #(.N(11)) u_ss (.clk(clk), .en(en), .d(ss), .q(ss_d));
	gkf_dly #(.N(11)) u_cs (.clk(clk), .en(en), .d(cs), .q(cs_d));
	gkf_dly #(.N(12)) u_x2 (.clk(clk), .en(en), .d(x2), .q(x2_o));

	// terms alternate in sign
	always_ff @(posedge clk) begin
		if (en) begin
			st_o <= -qs;
			ss_o <= sat_add(ss_d, -qs);
			ct_o <= -qc;
			cs_o <= sat_add(cs_d, -qc);
		end
	end

endmodule

// ===== src/gkf_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a point, converts angles to Q30, forms the meridian offset and prefix.
// Uses gkf_pkg.
module gkf_front import gkf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 29
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [71:0] in_data,
	output logic        push_valid,
	input  logic        push_ready,
	output pt_t         push_data
);

	logic vld_q;
	pt_t pt_q;
	word_t lat_x, lon_x, lat_w, lon_w;
	logic [5:0] zone;

	assign lat_x = {{33{in_data[30]}}, in_data[30:0]};
	assign lon_x = {{32{in_data[62]}}, in_data[62:31]};
	assign zone = in_data[68:63];

	if (ANGLE_FRAC_BITS >= WF) begin : g_dn
		assign lat_w = lat_x >>> (ANGLE_FRAC_BITS - WF);
		assign lon_w = lon_x >>> (ANGLE_FRAC_BITS - WF);
	end else begin : g_up
		assign lat_w = lat_x <<< (WF - ANGLE_FRAC_BITS);
		assign lon_w = lon_x <<< (WF - ANGLE_FRAC_BITS);
	end

	assign in_ready = !vld_q || push_ready;
	assign push_valid = vld_q;
	assign push_data = pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pt_q.lat <= lat_w;
			pt_q.lon_off <= lon_w - CM_TAB[zone];
			pt_q.prefix <= (64'(zone) * 64'sd10 + 64'sd5) * 64'sd1000000000;
		end
	end

endmodule

// ===== src/gkf_queue.sv =====
`timescale 1ns / 1ps
// Four-entry queue of converted points between the front end and the datapath.
// Uses gkf_pkg.
module gkf_queue import gkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  pt_t  push_data,
	output logic pop_valid,
	input  logic pop,
	output pt_t  pop_data
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	pt_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push;

	assign push_ready = cnt_q != (AW+1)'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("queue popped while empty");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue lost a transfer");

endmodule

// ===== src/gkf_back.sv =====
`timescale 1ns / 1ps
// Datapath: sine/cosine series, GOST cubics, Horner nesting and millimetre rounding.
// One stall enable for the whole pipeline. Uses gkf_pkg and the arithmetic units.
module gkf_back import gkf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_pop,
	input  pt_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NORTH_W-1:0]   northing_mm,
	output logic [EAST_W-1:0]    easting_mm
);

	localparam int LAT_MUL = 2;
	localparam int LAT_TSTEP = 12;
	localparam int LAT_HSTEP = 3;
	localparam int LAT_DIV = 9;
	localparam int T_TRIG = LAT_MUL + 9 * LAT_TSTEP;
	localparam int T_PROD = T_TRIG + LAT_MUL;
	localparam int T_POLY = T_PROD + 3 * LAT_HSTEP;
	localparam int T_Y = T_POLY + 4 * LAT_HSTEP;
	localparam int T_X = T_POLY + 5 * LAT_HSTEP;
	localparam int LB = T_X + LAT_DIV + 1;

	logic en;
	logic [LB-1:0] vld_q;

	assign en = !vld_q[LB-1] || out_ready;
	assign in_pop = en && in_valid;
	assign out_valid = vld_q[LB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LB-2:0], in_valid};
		end
	end

	// sine and cosine of latitude
	word_t x2, lat_d2;
	word_t x2c [10], st [10], ss [10], ct [10], cs [10];

	gkf_mulshr #(.SH(WF)) u_x2 (.clk(clk), .en(en), .a(in_data.lat), .b(in_data.lat), .y(x2));
	gkf_dly #(.N(LAT_MUL)) u_lat2 (.clk(clk), .en(en), .d(in_data.lat), .q(lat_d2));

	assign x2c[0] = x2;
	assign st[0] = lat_d2;
	assign ss[0] = lat_d2;
	assign ct[0] = ONE_Q30;
	assign cs[0] = ONE_Q30;

	for (genvar k = 0; k < 9; k++) begin : g_trig
		gkf_tstep #(.SD(SIN_DIV[k]), .CD(COS_DIV[k])) u_ts (
			.clk(clk), .en(en),
			.x2(x2c[k]), .st(st[k]), .ss(ss[k]), .ct(ct[k]), .cs(cs[k]),
			.x2_o(x2c[k+1]), .st_o(st[k+1]), .ss_o(ss[k+1]), .ct_o(ct[k+1]), .cs_o(cs[k+1])
		);
	end

	// products of the trig results
	word_t lat_d, lon_d, pre_d;
	word_t s, s2b, t, lc, mlat;

	gkf_dly #(.N(T_TRIG)) u_latd (.clk(clk), .en(en), .d(in_data.lat), .q(lat_d));
	gkf_dly #(.N(T_TRIG)) u_lond (.clk(clk), .en(en), .d(in_data.lon_off), .q(lon_d));
	gkf_dly #(.N(T_Y - LAT_HSTEP)) u_pre (.clk(clk), .en(en), .d(in_data.prefix), .q(pre_d));

	gkf_mulshr #(.SH(WF)) u_s (.clk(clk), .en(en), .a(ss[9]), .b(ss[9]), .y(s));
	gkf_mulshr #(.SH(WF-1)) u_s2b (.clk(clk), .en(en), .a(ss[9]), .b(cs[9]), .y(s2b));
	gkf_mulshr #(.SH(WF)) u_t (.clk(clk), .en(en), .a(lon_d), .b(lon_d), .y(t));
	gkf_mulshr #(.SH(WF)) u_lc (.clk(clk), .en(en), .a(lon_d), .b(cs[9]), .y(lc));
	gkf_mulshr #(.SH(WF)) u_ml (.clk(clk), .en(en), .a(MERID_COEF), .b(lat_d), .y(mlat));

	// cubics in s: P0..P4 at index 0..4, Q0..Q3 at index 5..8
	word_t cub_y [9][3];
	word_t cub_b [9][3];
	word_t poly [9];

	for (genvar i = 0; i < 9; i++) begin : g_cub
		for (genvar j = 0; j < 3; j++) begin : g_st
			word_t a_in, b_in;
			if (j == 0) begin : g_h
				assign a_in = poly_coef(i, 3);
				assign b_in = s;
			end else begin : g_t
				assign a_in = cub_y[i][j-1];
				assign b_in = cub_b[i][j-1];
			end
			gkf_hstep #(.NEG(1'b0)) u_h (
				.clk(clk), .en(en), .a(a_in), .b(b_in), .c(poly_coef(i, 2 - j)),
				.y(cub_y[i][j]), .b_o(cub_b[i][j])
			);
		end
		assign poly[i] = cub_y[i][2];
	end

	// nesting in t
	word_t t_d, s2b_d, mlat_d, lc_d;
	word_t p2_d, p1_d, p0_d, q1_d, q0_d;
	word_t xa1, xa2, xa3, xa4, xb1, xb2, xb3, xb4, xv, xbf;
	word_t ya1, ya2, ya3, yb1, yb2, yb3, yv, yv_d, ybf;

	gkf_dly #(.N(T_POLY - T_PROD)) u_td (.clk(clk), .en(en), .d(t), .q(t_d));
	gkf_dly #(.N(T_X - LAT_HSTEP - T_PROD)) u_s2bd (.clk(clk), .en(en), .d(s2b), .q(s2b_d));
	gkf_dly #(.N(T_X - LAT_HSTEP - T_PROD)) u_mld (.clk(clk), .en(en), .d(mlat), .q(mlat_d));
	gkf_dly #(.N(T_Y - LAT_HSTEP - T_PROD)) u_lcd (.clk(clk), .en(en), .d(lc), .q(lc_d));
	gkf_dly #(.N(LAT_HSTEP)) u_p2 (.clk(clk), .en(en), .d(poly[2]), .q(p2_d));
	gkf_dly #(.N(2 * LAT_HSTEP)) u_p1 (.clk(clk), .en(en), .d(poly[1]), .q(p1_d));
	gkf_dly #(.N(3 * LAT_HSTEP)) u_p0 (.clk(clk), .en(en), .d(poly[0]), .q(p0_d));
	gkf_dly #(.N(LAT_HSTEP)) u_q1 (.clk(clk), .en(en), .d(poly[6]), .q(q1_d));
	gkf_dly #(.N(2 * LAT_HSTEP)) u_q0 (.clk(clk), .en(en), .d(poly[5]), .q(q0_d));

	gkf_hstep #(.NEG(1'b0)) u_hx1 (.clk(clk), .en(en), .a(poly[4]), .b(t_d), .c(poly[3]),
		.y(xa1), .b_o(xb1));
	gkf_hstep #(.NEG(1'b0)) u_hx2 (.clk(clk), .en(en), .a(xa1), .b(xb1), .c(p2_d),
		.y(xa2), .b_o(xb2));
	gkf_hstep #(.NEG(1'b0)) u_hx3 (.clk(clk), .en(en), .a(xa2), .b(xb2), .c(p1_d),
		.y(xa3), .b_o(xb3));
	gkf_hstep #(.NEG(1'b1)) u_hx4 (.clk(clk), .en(en), .a(xa3), .b(xb3), .c(p0_d),
		.y(xa4), .b_o(xb4));
	gkf_hstep #(.NEG(1'b1)) u_hxf (.clk(clk), .en(en), .a(xa4), .b(s2b_d), .c(mlat_d),
		.y(xv), .b_o(xbf));

	gkf_hstep #(.NEG(1'b0)) u_hy1 (.clk(clk), .en(en), .a(poly[8]), .b(t_d), .c(poly[7]),
		.y(ya1), .b_o(yb1));
	gkf_hstep #(.NEG(1'b0)) u_hy2 (.clk(clk), .en(en), .a(ya1), .b(yb1), .c(q1_d),
		.y(ya2), .b_o(yb2));
	gkf_hstep #(.NEG(1'b0)) u_hy3 (.clk(clk), .en(en), .a(ya2), .b(yb2), .c(q0_d),
		.y(ya3), .b_o(yb3));
	gkf_hstep #(.NEG(1'b0)) u_hyf (.clk(clk), .en(en), .a(ya3), .b(lc_d), .c(pre_d),
		.y(yv), .b_o(ybf));
	gkf_dly #(.N(T_X - T_Y)) u_yal (.clk(clk), .en(en), .d(yv), .q(yv_d));

	// 1e-4 m to mm, half up, then saturate into the output register
	word_t xm, ym;

	gkf_divc #(.D(10), .FLOOR(1'b1)) u_xmm (.clk(clk), .en(en), .v(xv + 64'sd5), .q(xm));
	gkf_divc #(.D(10), .FLOOR(1'b1)) u_ymm (.clk(clk), .en(en), .v(yv_d + 64'sd5), .q(ym));

	always_ff @(posedge clk) begin
		if (en) begin
			northing_mm <= (xm < NORTH_LO) ? NORTH_LO[NORTH_W-1:0] :
				(xm > NORTH_HI) ? NORTH_HI[NORTH_W-1:0] : xm[NORTH_W-1:0];
			easting_mm <= (ym < EAST_LO) ? EAST_LO[EAST_W-1:0] :
				(ym > EAST_HI) ? EAST_HI[EAST_W-1:0] : ym[EAST_W-1:0];
		end
	end

endmodule
